>>> hw/rtl/ttf_pkg.sv
// Shared types and constants for the target track filter.
// Holds the channel payload structs, configuration layout and controller commands.
// No dependencies.
package ttf_pkg;

    typedef struct packed {
        logic               detected;
        logic signed [31:0] meas_pos_x;
        logic signed [31:0] meas_pos_y;
        logic signed [31:0] meas_pos_z;
        logic        [31:0] frame_time_ms;
    } in_item_t;

    typedef struct packed {
        logic               pose_valid;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_z;
        logic               holding;
        logic               track_locked;
        logic        [15:0] missed_count;
    } out_item_t;

    typedef struct packed {
        logic [23:0] process_noise;
        logic [23:0] measurement_noise;
        logic [15:0] hold_timeout_ms;
        logic [9:0]  max_missed_frames;
        logic [23:0] initial_covariance;
    } cfg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROCESS_NOISE      = 3'd0,
        CFG_MEASUREMENT_NOISE  = 3'd1,
        CFG_HOLD_TIMEOUT_MS    = 3'd2,
        CFG_MAX_MISSED_FRAMES  = 3'd3,
        CFG_INITIAL_COVARIANCE = 3'd4
    } cfg_index_t;

    localparam logic [23:0] PROCESS_NOISE_RST      = 24'd655;
    localparam logic [23:0] MEASUREMENT_NOISE_RST  = 24'd6554;
    localparam logic [15:0] HOLD_TIMEOUT_MS_RST    = 16'd1000;
    localparam logic [9:0]  MAX_MISSED_FRAMES_RST  = 10'd10;
    localparam logic [23:0] INITIAL_COVARIANCE_RST = 24'd65536;

    // Multiply sequence: x, y, z axis updates, then covariance; one extra phase drains
    localparam int          MUL_PHASE_W   = 3;
    localparam logic [MUL_PHASE_W-1:0] PH_AXIS_X = 3'd0;
    localparam logic [MUL_PHASE_W-1:0] PH_AXIS_Y = 3'd1;
    localparam logic [MUL_PHASE_W-1:0] PH_AXIS_Z = 3'd2;
    localparam logic [MUL_PHASE_W-1:0] PH_COV    = 3'd3;
    localparam logic [MUL_PHASE_W-1:0] PH_DRAIN  = 3'd4;

    typedef struct packed {
        logic                   load;
        logic                   div_step;
        logic                   mul_step;
        logic [MUL_PHASE_W-1:0] phase;
        logic                   finish;
    } ctrl_cmd_t;

endpackage

>>> hw/rtl/ttf_ctrl.sv
// Controller for the target track filter: sequences accept, divide, multiply, finish.
// Misses skip divide and multiply. Depends on ttf_pkg for the command struct.
module ttf_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_detected,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output ttf_pkg::ctrl_cmd_t cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.phase      = cnt_reg[ttf_pkg::MUL_PHASE_W-1:0];
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = s_detected ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS)) begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(ttf_pkg::PH_DRAIN)) begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                // hold the result until the output register frees up
                if (!out_valid_reg || m_ready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

>>> hw/rtl/ttf_datapath.sv
// Datapath for the target track filter: track state, gain divider, shared multiplier
// and output register. Driven by commands from ttf_ctrl; depends on ttf_pkg.
module ttf_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ttf_pkg::ctrl_cmd_t cmd,
    input  ttf_pkg::cfg_t      cfg,
    input  ttf_pkg::in_item_t  s_data,
    output ttf_pkg::out_item_t m_data
);

    localparam int GW = FRAC_BITS + 1;   // gain width, gain <= 1.0
    localparam int MW = 33;              // magnitude operand width
    localparam int PW = MW + GW;         // product width
    localparam int RW = 34;              // divider remainder width
    localparam logic [GW-1:0] ONE_G = GW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF  = PW'(1) << (FRAC_BITS - 1);

    ttf_pkg::in_item_t  in_reg;
    ttf_pkg::out_item_t out_reg;

    logic [31:0]   est_x_reg, est_y_reg, est_z_reg;
    logic [31:0]   cov_reg;
    logic          locked_reg;
    logic [15:0]   miss_reg;
    logic          known_reg;
    logic          running_reg;
    logic [31:0]   start_reg;

    logic [31:0]   p_reg;
    logic [32:0]   den_reg;
    logic          den_zero_reg;
    logic [RW-1:0] rem_reg;
    logic [GW-1:0] quot_reg;
    logic [PW-1:0] prod_reg;
    logic          neg_reg;

    // predicted covariance, also the miss-path covariance
    logic [32:0]   p_sum;
    logic [31:0]   p_sat;
    logic [32:0]   den;

    logic          div_ge;
    logic [RW-1:0] rem_after;

    logic [GW-1:0] gain_eff;
    logic [31:0]   est_sel;
    logic [31:0]   meas_sel;
    logic [32:0]   diff;
    logic          diff_neg;
    logic [MW-1:0] mag;
    logic [MW-1:0] mul_a;
    logic [GW-1:0] mul_b;
    logic [PW-1:0] product;

    logic [PW-1:0] rounded;
    logic [31:0]   delta;
    logic [31:0]   est_apply;
    logic [31:0]   est_upd;
    logic [31:0]   cov_upd;

    logic [15:0]   miss_inc;
    logic [31:0]   start_eff;
    logic [31:0]   elapsed;
    logic          hold;
    logic          drop;

    always_comb begin
        p_sum = {1'b0, cov_reg} + 33'(cfg.process_noise);
        p_sat = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
        den   = {1'b0, p_sat} + 33'(cfg.measurement_noise);
    end

    // restoring divider, one quotient bit per step
    always_comb begin
        div_ge    = (rem_reg >= RW'(den_reg));
        rem_after = div_ge ? (rem_reg - RW'(den_reg)) : rem_reg;
    end

    // operand select for the shared multiplier
    always_comb begin
        gain_eff = den_zero_reg ? '0 : quot_reg;
        case (cmd.phase)
            ttf_pkg::PH_AXIS_X: begin est_sel = est_x_reg; meas_sel = in_reg.meas_pos_x; end
            ttf_pkg::PH_AXIS_Y: begin est_sel = est_y_reg; meas_sel = in_reg.meas_pos_y; end
            ttf_pkg::PH_AXIS_Z: begin est_sel = est_z_reg; meas_sel = in_reg.meas_pos_z; end
            default:            begin est_sel = est_x_reg; meas_sel = in_reg.meas_pos_x; end
        endcase
        diff     = {meas_sel[31], meas_sel} - {est_sel[31], est_sel};
        diff_neg = diff[32];
        mag      = diff_neg ? (MW'(0) - diff) : diff;
        if (cmd.phase == ttf_pkg::PH_COV) begin
            mul_a = {1'b0, p_reg};
            mul_b = ONE_G - gain_eff;
        end else begin
            mul_a = mag;
            mul_b = gain_eff;
        end
        product = PW'(mul_a) * PW'(mul_b);
    end

    // apply the product registered in the previous phase
    always_comb begin
        case (cmd.phase)
            ttf_pkg::PH_AXIS_Y: est_apply = est_x_reg;
            ttf_pkg::PH_COV:    est_apply = est_z_reg;
            default:            est_apply = est_y_reg;
        endcase
        rounded = prod_reg + HALF;
        delta   = rounded[FRAC_BITS +: 32];
        est_upd = neg_reg ? (est_apply - delta) : (est_apply + delta);
        cov_upd = prod_reg[FRAC_BITS +: 32];
    end

    // missed-frame bookkeeping
    always_comb begin
        miss_inc  = (miss_reg != 16'hFFFF) ? (miss_reg + 16'd1) : miss_reg;
        start_eff = running_reg ? start_reg : in_reg.frame_time_ms;
        elapsed   = in_reg.frame_time_ms - start_eff;
        hold      = known_reg && (elapsed <= 32'(cfg.hold_timeout_ms));
        drop      = !hold && (miss_inc > 16'(cfg.max_missed_frames));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_x_reg   <= '0;
            est_y_reg   <= '0;
            est_z_reg   <= '0;
            cov_reg     <= 32'(ttf_pkg::INITIAL_COVARIANCE_RST);
            locked_reg  <= 1'b0;
            miss_reg    <= '0;
            known_reg   <= 1'b0;
            running_reg <= 1'b0;
            start_reg   <= '0;
        end else begin
            if (cmd.mul_step) begin
                case (cmd.phase)
                    ttf_pkg::PH_AXIS_Y: est_x_reg <= est_upd;
                    ttf_pkg::PH_AXIS_Z: est_y_reg <= est_upd;
                    ttf_pkg::PH_COV:    est_z_reg <= est_upd;
                    ttf_pkg::PH_DRAIN:  cov_reg   <= cov_upd;
                    default: begin
                    end
                endcase
            end
            if (cmd.finish) begin
                if (in_reg.detected) begin
                    locked_reg  <= 1'b1;
                    miss_reg    <= '0;
                    known_reg   <= 1'b1;
                    running_reg <= 1'b0;
                    start_reg   <= '0;
                end else if (drop) begin
                    // drop the track entirely
                    est_x_reg   <= '0;
                    est_y_reg   <= '0;
                    est_z_reg   <= '0;
                    cov_reg     <= 32'(cfg.initial_covariance);
                    locked_reg  <= 1'b0;
                    miss_reg    <= '0;
                    known_reg   <= 1'b0;
                    running_reg <= 1'b0;
                    start_reg   <= '0;
                end else begin
                    cov_reg     <= p_sat;
                    miss_reg    <= miss_inc;
                    running_reg <= 1'b1;
                    start_reg   <= start_eff;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg       <= s_data;
            p_reg        <= p_sat;
            den_reg      <= den;
            den_zero_reg <= (den == '0);
            rem_reg      <= RW'(p_sat);
            quot_reg     <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= {rem_after[RW-2:0], 1'b0};
            quot_reg <= {quot_reg[GW-2:0], div_ge};
        end
        if (cmd.mul_step && (cmd.phase != ttf_pkg::PH_DRAIN)) begin
            prod_reg <= product;
            neg_reg  <= diff_neg;
        end
        if (cmd.finish) begin
            if (in_reg.detected) begin
                out_reg.pose_valid   <= 1'b1;
                out_reg.pose_x       <= est_x_reg;
                out_reg.pose_y       <= est_y_reg;
                out_reg.pose_z       <= est_z_reg;
                out_reg.holding      <= 1'b0;
                out_reg.track_locked <= 1'b1;
                out_reg.missed_count <= '0;
            end else begin
                out_reg.pose_valid   <= hold;
                out_reg.pose_x       <= hold ? est_x_reg : '0;
                out_reg.pose_y       <= hold ? est_y_reg : '0;
                out_reg.pose_z       <= hold ? est_z_reg : '0;
                out_reg.holding      <= hold;
                out_reg.track_locked <= drop ? 1'b0 : locked_reg;
                out_reg.missed_count <= drop ? 16'd0 : miss_inc;
            end
        end
    end

    assign m_data = out_reg;

endmodule

>>> hw/rtl/target_track_filter_core.sv
// Target track filter top level: one result per camera frame.
// Detected frame: accept, then the F+1 step gain divider and the five-phase shared
// multiplier, then the result. Missed frame: accept goes straight to the result.
// One item in flight at a time; next item accepted once the result is registered.
// Synchronous active-low reset restores the configuration, the track state and the controller.
// Instantiates ttf_ctrl and ttf_datapath; depends on ttf_pkg.
module target_track_filter_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ttf_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ttf_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ttf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ttf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ttf_pkg::cfg_t      cfg_reg;
    ttf_pkg::ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.process_noise      <= ttf_pkg::PROCESS_NOISE_RST;
            cfg_reg.measurement_noise  <= ttf_pkg::MEASUREMENT_NOISE_RST;
            cfg_reg.hold_timeout_ms    <= ttf_pkg::HOLD_TIMEOUT_MS_RST;
            cfg_reg.max_missed_frames  <= ttf_pkg::MAX_MISSED_FRAMES_RST;
            cfg_reg.initial_covariance <= ttf_pkg::INITIAL_COVARIANCE_RST;
        end else if (cfg_valid && cfg_ready) begin
            // ignore indexes past the register list
            case (cfg_index)
                ttf_pkg::CFG_PROCESS_NOISE:      cfg_reg.process_noise      <= cfg_data;
                ttf_pkg::CFG_MEASUREMENT_NOISE:  cfg_reg.measurement_noise  <= cfg_data;
                ttf_pkg::CFG_HOLD_TIMEOUT_MS:    cfg_reg.hold_timeout_ms    <= cfg_data[15:0];
                ttf_pkg::CFG_MAX_MISSED_FRAMES:  cfg_reg.max_missed_frames  <= cfg_data[9:0];
                ttf_pkg::CFG_INITIAL_COVARIANCE: cfg_reg.initial_covariance <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ttf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_detected (s_data.detected),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd)
    );

    ttf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .m_data  (m_data)
    );

    // a missed frame accepted with the output register free passes the finish state, then raises m_valid
    a_miss_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_data.detected && !m_valid) |=> ##1 m_valid)
        else $error("missed-frame transaction did not produce a result in time");

    // a held pose always comes from a locked track
    a_hold_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.holding) |-> (m_data.pose_valid && m_data.track_locked))
        else $error("holding result without valid pose or lock");

    // an invalid pose carries zero coordinates
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.pose_valid) |->
        (m_data.pose_x == '0 && m_data.pose_y == '0 && m_data.pose_z == '0))
        else $error("invalid pose with nonzero coordinates");

    // a fresh detection clears the miss count
    a_fresh_no_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.pose_valid && !m_data.holding) |->
        (m_data.missed_count == '0 && m_data.track_locked))
        else $error("fresh pose with nonzero miss count or no lock");

endmodule

>>> tb/tb_target_track_filter_core.sv
// Testbench for target_track_filter_core: directed and random camera frames under
// several filter settings, with a Kalman track predictor checking every pose.
// Depends on ttf_pkg and the target_track_filter_core RTL.
`timescale 1ns / 100ps

module tb_target_track_filter_core;

    localparam int          FRAC_W         = 16;
    localparam int          STALL_LIMIT    = 4000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          ITEMS_PER_SET  = 230;
    localparam int          SAT_FRAMES     = 300;
    localparam logic [2:0]  CFG_SPARE_BASE = 3'd5;

    // Holds the expected track state and the poses still owed by the block.
    class track_pose_board;
        ttf_pkg::cfg_t      regs;
        logic [31:0]        est [3];
        logic [31:0]        cov;
        logic               locked;
        logic               known;
        logic               timer_on;
        logic [15:0]        misses;
        logic [31:0]        lost_since;
        ttf_pkg::out_item_t pose_q [$];
        int unsigned        error_count;

        function new();
            regs.process_noise      = ttf_pkg::PROCESS_NOISE_RST;
            regs.measurement_noise  = ttf_pkg::MEASUREMENT_NOISE_RST;
            regs.hold_timeout_ms    = ttf_pkg::HOLD_TIMEOUT_MS_RST;
            regs.max_missed_frames  = ttf_pkg::MAX_MISSED_FRAMES_RST;
            regs.initial_covariance = ttf_pkg::INITIAL_COVARIANCE_RST;
            error_count = 0;
            drop_track();
        endfunction

        function void drop_track();
            est[0]     = '0;
            est[1]     = '0;
            est[2]     = '0;
            cov        = {8'b0, regs.initial_covariance};
            locked     = 1'b0;
            known      = 1'b0;
            timer_on   = 1'b0;
            misses     = '0;
            lost_since = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] value);
            case (idx)
                ttf_pkg::CFG_PROCESS_NOISE:      regs.process_noise      = value;
                ttf_pkg::CFG_MEASUREMENT_NOISE:  regs.measurement_noise  = value;
                ttf_pkg::CFG_HOLD_TIMEOUT_MS:    regs.hold_timeout_ms    = value[15:0];
                ttf_pkg::CFG_MAX_MISSED_FRAMES:  regs.max_missed_frames  = value[9:0];
                ttf_pkg::CFG_INITIAL_COVARIANCE: regs.initial_covariance = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        // Move one axis toward the measurement; round the step to nearest, ties away from zero.
        function logic [31:0] blend_axis(logic [31:0] cur, logic [31:0] meas, logic [63:0] gain);
            logic signed [33:0] diff;
            logic        [33:0] mag;
            logic        [63:0] step;
            diff = $signed({{2{meas[31]}}, meas}) - $signed({{2{cur[31]}}, cur});
            mag  = diff[33] ? (~diff + 34'd1) : diff;
            step = ({30'b0, mag} * gain + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
            return diff[33] ? cur - step[31:0] : cur + step[31:0];
        endfunction

        function void note_frame(ttf_pkg::in_item_t f);
            logic [31:0]        meas [3];
            logic [31:0]        p;
            logic [31:0]        elapsed;
            logic [63:0]        p_w;
            logic [63:0]        den;
            logic [63:0]        gain;
            ttf_pkg::out_item_t pose;
            meas[0] = f.meas_pos_x;
            meas[1] = f.meas_pos_y;
            meas[2] = f.meas_pos_z;
            pose = '0;
            if (f.detected) begin
                p    = add_clamped(cov, {8'b0, regs.process_noise});
                p_w  = {32'b0, p};
                den  = p_w + {40'b0, regs.measurement_noise};
                gain = (den == 64'd0) ? 64'd0 : (p_w << FRAC_W) / den;
                for (int a = 0; a < 3; a++) est[a] = blend_axis(est[a], meas[a], gain);
                cov        = 32'((((64'd1 << FRAC_W) - gain) * p_w) >> FRAC_W);
                locked     = 1'b1;
                known      = 1'b1;
                timer_on   = 1'b0;
                misses     = '0;
                lost_since = '0;
                pose.pose_valid = 1'b1;
                pose.pose_x     = est[0];
                pose.pose_y     = est[1];
                pose.pose_z     = est[2];
            end else begin
                cov = add_clamped(cov, {8'b0, regs.process_noise});
                if (misses != 16'hFFFF) misses = misses + 16'd1;
                if (!timer_on) begin
                    timer_on   = 1'b1;
                    lost_since = f.frame_time_ms;
                end
                elapsed = f.frame_time_ms - lost_since;
                if (known && elapsed <= {16'b0, regs.hold_timeout_ms}) begin
                    pose.pose_valid = 1'b1;
                    pose.holding    = 1'b1;
                    pose.pose_x     = est[0];
                    pose.pose_y     = est[1];
                    pose.pose_z     = est[2];
                end else if (misses > {6'b0, regs.max_missed_frames}) begin
                    drop_track();
                end
            end
            pose.track_locked = locked;
            pose.missed_count = misses;
            pose_q.push_back(pose);
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            error_count++;
            $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
        endtask

        task check_pose(ttf_pkg::out_item_t got);
            ttf_pkg::out_item_t want;
            if (pose_q.size() == 0) begin
                report("unexpected pose", '0, got.pose_x);
                return;
            end
            want = pose_q.pop_front();
            if (got.pose_valid !== want.pose_valid)
                report("pose_valid", 32'(want.pose_valid), 32'(got.pose_valid));
            if (got.pose_x !== want.pose_x) report("pose_x", want.pose_x, got.pose_x);
            if (got.pose_y !== want.pose_y) report("pose_y", want.pose_y, got.pose_y);
            if (got.pose_z !== want.pose_z) report("pose_z", want.pose_z, got.pose_z);
            if (got.holding !== want.holding)
                report("holding", 32'(want.holding), 32'(got.holding));
            if (got.track_locked !== want.track_locked)
                report("track_locked", 32'(want.track_locked), 32'(got.track_locked));
            if (got.missed_count !== want.missed_count)
                report("missed_count", 32'(want.missed_count), 32'(got.missed_count));
        endtask

        function int pending();
            return pose_q.size();
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    ttf_pkg::in_item_t               s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    ttf_pkg::out_item_t              m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ttf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ttf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    track_pose_board sb = new();
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     stall_cycles  = 0;
    logic [31:0]     stamp_ms      = '0;

    target_track_filter_core #(.FRAC_BITS(FRAC_W)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check poses and end the run if the channels go quiet for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_pose(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles == STALL_LIMIT) begin
                $display("target_track_filter_core test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_frame(input logic det, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] t);
        ttf_pkg::in_item_t f;
        f.detected      = det;
        f.meas_pos_x    = x;
        f.meas_pos_y    = y;
        f.meas_pos_z    = z;
        f.frame_time_ms = t;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= f;
        do @(posedge aclk); while (!s_ready);
        sb.note_frame(f);
    endtask

    // Drop valid and wait until every pose owed has been taken.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic program_regs(input ttf_pkg::cfg_t c);
        logic [2:0]  slot [6];
        logic [23:0] word [6];
        slot = '{ttf_pkg::CFG_PROCESS_NOISE, ttf_pkg::CFG_MEASUREMENT_NOISE,
                 ttf_pkg::CFG_HOLD_TIMEOUT_MS, ttf_pkg::CFG_MAX_MISSED_FRAMES,
                 ttf_pkg::CFG_INITIAL_COVARIANCE,
                 3'(CFG_SPARE_BASE + $urandom_range(0, 2))};
        // junk above the narrow registers must be dropped; the unmapped index is ignored
        word = '{c.process_noise, c.measurement_noise, {8'($urandom), c.hold_timeout_ms},
                 {14'($urandom), c.max_missed_frames}, c.initial_covariance, 24'($urandom)};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= slot[i];
            cfg_data  <= word[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(slot[i], word[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] next_stamp();
        case ($urandom_range(19))
            0: begin
                stamp_ms = $urandom;
            end
            1: begin
                stamp_ms = stamp_ms - $urandom_range(1, 2000);
            end
            2, 3: begin
                stamp_ms = stamp_ms + $urandom_range(0, 70000);
            end
            4: ;
            default: begin
                stamp_ms = stamp_ms + $urandom_range(1, 40);
            end
        endcase
        return stamp_ms;
    endfunction

    function automatic logic [31:0] pick_position();
        case ($urandom_range(7))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        endcase
    endfunction

    task automatic directed_frames();
        ttf_pkg::cfg_t zeros;
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'd0);
        send_frame(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'd100);
        send_frame(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd110);
        send_frame(1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 32'd120);
        // hold right up to the timeout, then one past it
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'd200);
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'd1200);
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'd1201);
        send_frame(1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'd1300);
        // lost timer across the 32-bit wrap, then time going backwards
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FF00);
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_0100);
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_0000);
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FE00);
        // run the miss count past its limit to drop the track
        for (int i = 1; i <= 7; i++) send_frame(1'b0, $urandom, $urandom, $urandom, 32'h1000 * i);
        send_frame(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle();
        // zero noise and zero covariance: the gain denominator goes to zero
        zeros = '{24'd0, 24'd0, 16'd0, 10'd0, 24'd0};
        program_regs(zeros);
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'd5);
        send_frame(1'b0, 32'h0, 32'h0, 32'h0, 32'd6);
        send_frame(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'd7);
        send_frame(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hEDCB_A988, 32'd8);
        settle();
    endtask

    // Tracks: a run of detections around one target, then a run of misses; some noise frames.
    task automatic run_tracks(input int unsigned n_items);
        int unsigned sent;
        int unsigned det_len;
        int unsigned miss_len;
        logic [31:0] tgt [3];
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_frame(1'($urandom_range(1)), $urandom, $urandom, $urandom, next_stamp());
                sent++;
            end else begin
                for (int a = 0; a < 3; a++) tgt[a] = pick_position();
                det_len  = $urandom_range(1, 12);
                miss_len = ($urandom_range(3) == 0) ? $urandom_range(0, 64)
                                                    : $urandom_range(0, 12);
                repeat (det_len)
                    send_frame(1'b1, tgt[0] + $urandom_range(0, 16383) - 32'd8192,
                               tgt[1] + $urandom_range(0, 16383) - 32'd8192,
                               tgt[2] + $urandom_range(0, 16383) - 32'd8192, next_stamp());
                repeat (miss_len)
                    send_frame(1'b0, $urandom, $urandom, $urandom, next_stamp());
                sent += det_len + miss_len;
            end
        end
        settle();
    endtask

    // Freeze time while holding so the covariance saturates.
    task automatic run_saturation();
        logic [31:0] t0;
        t0 = $urandom;
        send_frame(1'b1, $urandom, $urandom, $urandom, t0);
        repeat (SAT_FRAMES) send_frame(1'b0, $urandom, $urandom, $urandom, t0);
        send_frame(1'b1, $urandom, $urandom, $urandom, t0);
        send_frame(1'b0, $urandom, $urandom, $urandom, t0 + 32'd70000);
        settle();
    endtask

    initial begin
        ttf_pkg::cfg_t setting;
        send_idle_pct = 22;
        recv_idle_pct = 85;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_frames();

        setting = '{24'($urandom_range(0, 4000)), 24'($urandom_range(0, 20000)),
                    16'($urandom_range(0, 300)), 10'($urandom_range(0, 15)),
                    24'($urandom_range(0, 32'h0010_0000))};
        program_regs(setting);
        run_tracks(ITEMS_PER_SET);

        setting = '{24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 10'h3FF, 24'hFF_FFFF};
        program_regs(setting);
        run_tracks(ITEMS_PER_SET);

        send_idle_pct = 85;
        recv_idle_pct = 22;
        setting = '{24'd0, 24'hFF_FFFF, 16'd50, 10'd1, 24'd0};
        program_regs(setting);
        run_tracks(ITEMS_PER_SET);

        setting = '{24'($urandom), 24'($urandom), 16'($urandom), 10'($urandom), 24'($urandom)};
        program_regs(setting);
        run_tracks(ITEMS_PER_SET);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        setting = '{24'd1, 24'd1, 16'd0, 10'd0, 24'd1};
        program_regs(setting);
        run_tracks(ITEMS_PER_SET);

        setting = '{ttf_pkg::PROCESS_NOISE_RST, ttf_pkg::MEASUREMENT_NOISE_RST,
                    ttf_pkg::HOLD_TIMEOUT_MS_RST, ttf_pkg::MAX_MISSED_FRAMES_RST,
                    ttf_pkg::INITIAL_COVARIANCE_RST};
        program_regs(setting);
        run_tracks(ITEMS_PER_SET);

        setting = '{24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 10'h3FF, 24'hFF_FFFF};
        program_regs(setting);
        run_saturation();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("target_track_filter_core test passed");
        else
            $display("target_track_filter_core test failed");
        $finish;
    end

endmodule
